// File: src/g6d_pkg.sv
// Package for the graph6 edge list decoder: sizes, character codes, enums and
// the word types of the input, the result and the internal job queue.
// No dependencies.
package g6d_pkg;

  // Sizes
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned VERT_W      = 18;
  localparam int unsigned COUNT_W     = 35;
  localparam int unsigned DIGIT_W     = 6;

  // Character codes
  localparam logic [7:0] CHAR_COLON = 8'd58;
  localparam logic [7:0] CHAR_BIAS  = 8'd63;
  localparam logic [7:0] CHAR_LONG  = 8'd126;

  // Header digit counter value when the third digit arrives
  localparam logic [1:0] HDR_LAST_DIGIT = 2'd2;

  // Top bit index of a body character
  localparam logic [2:0] BIT_TOP = 3'(DIGIT_W - 1);

  typedef enum logic [1:0] {
    KIND_EDGE   = 2'd0,
    KIND_VCOUNT = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_SIZE   = 2'd1,
    ERR_HEADER = 2'd2,
    ERR_TRUNC  = 2'd3
  } err_e;

  // Front parse phase
  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_COLON   = 3'd1,
    PH_DIGITS  = 3'd2,
    PH_BODY    = 3'd3,
    PH_DISCARD = 3'd4
  } ph_e;

  // Job operation handed from front to back
  typedef enum logic [1:0] {
    OP_VCOUNT = 2'd0,
    OP_BODY   = 2'd1,
    OP_ERROR  = 2'd2
  } op_e;

  // Back step within a job
  typedef enum logic [1:0] {
    ST_HEAD = 2'd0,
    ST_BIT  = 2'd1,
    ST_END  = 2'd2
  } step_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_word_t;

  typedef struct packed {
    kind_e              kind;
    logic [VERT_W-1:0]  higher_vertex;
    logic [VERT_W-1:0]  lower_vertex;
    logic [COUNT_W-1:0] tally;
    err_e               error_code;
    logic               last_of_run;
  } out_word_t;

  typedef struct packed {
    op_e                op;
    logic               eos;
    err_e               err;
    logic [DIGIT_W-1:0] bits;
    logic [VERT_W-1:0]  vt;
  } job_t;

endpackage

// File: src/g6d_fifo.sv
// Short job queue between the front parser and the back edge walker.
// Depends on g6d_pkg for the job word type.
module g6d_fifo #(
  parameter int unsigned Depth = g6d_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  g6d_pkg::job_t  wdata_i,
  output logic           full_o,
  input  logic           rd_i,
  output g6d_pkg::job_t  rdata_o,
  output logic           empty_o
);
  import g6d_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  // Advance pointers with wrap, track fill
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (rd_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_i && rd_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store words
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i && full_o |-> rd_i)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_i && empty_o))
    else $error("job queue read while empty");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("job queue fill count out of range");

endmodule

// File: src/g6d_front.sv
// Front parser: skips a leading colon, decodes the size header and turns the
// header, each body byte and each fault into job words for the back. Depends on g6d_pkg.
module g6d_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  g6d_pkg::in_word_t in_word_i,
  input  logic              q_full_i,
  output logic              job_push_o,
  output g6d_pkg::job_t     job_o
);
  import g6d_pkg::*;

  ph_e                phase_q, phase_d;
  logic [VERT_W-1:0]  acc_q, acc_d;
  logic [1:0]         cnt_q, cnt_d;

  logic               accept;
  logic [7:0]         b;
  logic               eos;
  logic [DIGIT_W-1:0] digit;
  logic               is_short;
  logic               is_long;
  logic               is_colon;
  logic               hdr_case;
  ph_e                hdr_next;
  logic               push;

  assign accept   = in_valid_i && !q_full_i;
  assign b        = in_word_i.data_byte;
  assign eos      = in_word_i.end_of_string;
  assign digit    = DIGIT_W'(b - CHAR_BIAS);
  assign is_short = (b >= CHAR_BIAS) && (b < CHAR_LONG);
  assign is_long  = (b == CHAR_LONG);
  assign is_colon = (b == CHAR_COLON);
  assign hdr_case = ((phase_q == PH_START) && !is_colon) || (phase_q == PH_COLON);
  assign hdr_next = is_short ? PH_BODY : (is_long ? PH_DIGITS : PH_DISCARD);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      case (phase_q)
        PH_START:   phase_d = is_colon ? PH_COLON : hdr_next;
        PH_COLON:   phase_d = hdr_next;
        PH_DIGITS: begin
          if ((cnt_q == '0) && is_long) begin
            phase_d = PH_DISCARD;
          end else if (cnt_q == HDR_LAST_DIGIT) begin
            phase_d = PH_BODY;
          end
        end
        PH_BODY:    phase_d = PH_BODY;
        PH_DISCARD: phase_d = PH_DISCARD;
        default:    phase_d = PH_START;
      endcase
      if (eos) begin
        phase_d = PH_START;
      end
    end
  end

  // Job word and header accumulator
  always_comb begin
    push   = 1'b0;
    job_o  = '{op: OP_ERROR, eos: eos, err: ERR_NONE, bits: digit, vt: '0};
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    if (hdr_case) begin
      if (is_short) begin
        push     = 1'b1;
        job_o.op = OP_VCOUNT;
        job_o.vt = VERT_W'(digit);
      end else if (is_long) begin
        acc_d = '0;
        cnt_d = '0;
        if (eos) begin
          push      = 1'b1;
          job_o.err = ERR_TRUNC;
        end
      end else begin
        push      = 1'b1;
        job_o.err = ERR_HEADER;
      end
    end else begin
      case (phase_q)
        PH_START: begin
          // Colon as the whole string
          if (eos) begin
            push      = 1'b1;
            job_o.err = ERR_HEADER;
          end
        end
        PH_DIGITS: begin
          if ((cnt_q == '0) && is_long) begin
            push      = 1'b1;
            job_o.err = ERR_SIZE;
          end else begin
            acc_d = {acc_q[VERT_W-DIGIT_W-1:0], digit};
            cnt_d = cnt_q + 1'b1;
            if (cnt_q == HDR_LAST_DIGIT) begin
              push     = 1'b1;
              job_o.op = OP_VCOUNT;
              job_o.vt = acc_d;
            end else if (eos) begin
              push      = 1'b1;
              job_o.err = ERR_TRUNC;
            end
          end
        end
        PH_BODY: begin
          push     = 1'b1;
          job_o.op = OP_BODY;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  assign job_push_o = accept && push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: src/g6d_back.sv
// Back walker: runs each job, steps the upper-triangle bits one per cycle while
// the result side keeps up, and emits result words through a hold stage and an
// output register. Depends on g6d_pkg.
module g6d_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  g6d_pkg::job_t      job_i,
  output logic               job_take_o,
  input  logic               pop_i,
  output logic               empty_o,
  output g6d_pkg::out_word_t out_word_o
);
  import g6d_pkg::*;

  logic               job_v_q, job_v_d;
  job_t               job_q;
  step_e              step_q, step_d;
  logic [2:0]         idx_q, idx_d;
  logic [VERT_W-1:0]  vt_q, vt_d, col_q, col_d, row_q, row_d;
  logic [COUNT_W-1:0] edges_q, edges_d;
  logic               hold_v_q, hold_v_d, hold_fin_q, hold_fin_d;
  out_word_t          hold_q, hold_d;
  logic               out_v_q, out_v_d;
  out_word_t          out_q, out_d;

  logic               active;
  logic               cur_bit;
  logic               gen;
  logic               finish;
  out_word_t          res;
  logic               out_free;
  logic               step_go;
  logic               fire;
  logic               hold_move;
  logic               load;
  logic [VERT_W-1:0]  row_inc;

  assign active   = (col_q < vt_q);
  assign cur_bit  = job_q.bits[idx_q];
  assign out_free = !out_v_q || pop_i;
  assign row_inc  = row_q + 1'b1;

  // Result of the current step
  always_comb begin
    gen    = 1'b0;
    finish = 1'b0;
    res    = '{kind: KIND_EDGE, higher_vertex: '0, lower_vertex: '0,
               tally: '0, error_code: ERR_NONE, last_of_run: 1'b0};
    case (step_q)
      ST_HEAD: begin
        gen = 1'b1;
        if (job_q.op == OP_VCOUNT) begin
          res.kind  = KIND_VCOUNT;
          res.tally = COUNT_W'(job_q.vt);
          finish    = !job_q.eos;
        end else begin
          res.kind       = KIND_ERROR;
          res.error_code = job_q.err;
          finish         = 1'b1;
        end
      end
      ST_BIT: begin
        if (!active) begin
          finish = !job_q.eos;
        end else begin
          gen               = cur_bit;
          res.higher_vertex = col_q + 1'b1;
          res.lower_vertex  = row_inc;
          finish            = (idx_q == '0) && !job_q.eos;
        end
      end
      ST_END: begin
        gen    = 1'b1;
        finish = 1'b1;
        if (active) begin
          res.kind       = KIND_ERROR;
          res.error_code = ERR_TRUNC;
        end else begin
          res.kind  = KIND_DONE;
          res.tally = edges_q;
        end
      end
      default: begin
        finish = 1'b1;
      end
    endcase
  end

  assign step_go    = job_v_q && (!gen || !hold_v_q || out_free);
  assign fire       = step_go && gen;
  assign load       = job_valid_i && (!job_v_q || (step_go && finish));
  assign job_take_o = load;
  assign hold_move  = hold_v_q && out_free && (hold_fin_q || fire);

  // Next step
  always_comb begin
    step_d  = step_q;
    idx_d   = idx_q;
    job_v_d = job_v_q;
    if (load) begin
      job_v_d = 1'b1;
      step_d  = (job_i.op == OP_BODY) ? ST_BIT : ST_HEAD;
      idx_d   = BIT_TOP;
    end else if (step_go && finish) begin
      job_v_d = 1'b0;
    end else if (step_go) begin
      case (step_q)
        ST_HEAD: step_d = ST_END;
        ST_BIT: begin
          if (!active || (idx_q == '0)) begin
            step_d = ST_END;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
        default: step_d = ST_END;
      endcase
    end
  end

  // Walk position and edge count
  always_comb begin
    vt_d    = vt_q;
    col_d   = col_q;
    row_d   = row_q;
    edges_d = edges_q;
    if (step_go) begin
      case (step_q)
        ST_HEAD: begin
          if (job_q.op == OP_VCOUNT) begin
            vt_d    = job_q.vt;
            col_d   = VERT_W'(1);
            row_d   = '0;
            edges_d = '0;
          end
        end
        ST_BIT: begin
          if (active) begin
            edges_d = edges_q + COUNT_W'(cur_bit);
            if (row_inc >= col_q) begin
              col_d = col_q + 1'b1;
              row_d = '0;
            end else begin
              row_d = row_inc;
            end
          end
        end
        default: begin
          col_d = col_q;
        end
      endcase
    end
  end

  // Hold one result back until its last flag is known
  always_comb begin
    hold_v_d   = hold_v_q;
    hold_fin_d = hold_fin_q;
    hold_d     = hold_q;
    out_v_d    = out_v_q;
    out_d      = out_q;
    if (hold_move) begin
      out_v_d           = 1'b1;
      out_d             = hold_q;
      out_d.last_of_run = hold_fin_q;
    end else if (pop_i) begin
      out_v_d = 1'b0;
    end
    if (fire) begin
      hold_v_d   = 1'b1;
      hold_fin_d = finish;
      hold_d     = res;
    end else if (hold_move) begin
      hold_v_d   = 1'b0;
      hold_fin_d = 1'b0;
    end else if (step_go && finish && hold_v_q) begin
      hold_fin_d = 1'b1;
    end
  end

  assign empty_o    = !out_v_q;
  assign out_word_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_v_q    <= 1'b0;
      step_q     <= ST_HEAD;
      idx_q      <= BIT_TOP;
      vt_q       <= '0;
      col_q      <= VERT_W'(1);
      row_q      <= '0;
      edges_q    <= '0;
      hold_v_q   <= 1'b0;
      hold_fin_q <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      job_v_q    <= job_v_d;
      step_q     <= step_d;
      idx_q      <= idx_d;
      vt_q       <= vt_d;
      col_q      <= col_d;
      row_q      <= row_d;
      edges_q    <= edges_d;
      hold_v_q   <= hold_v_d;
      hold_fin_q <= hold_fin_d;
      out_v_q    <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  a_edge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_q.kind == KIND_EDGE) |->
      (out_q.higher_vertex > out_q.lower_vertex))
    else $error("edge word with endpoints out of order");

  a_err_only_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_q.kind != KIND_ERROR) |-> (out_q.error_code == ERR_NONE))
    else $error("error code on a non-error word");

  a_fin_needs_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_fin_q |-> hold_v_q)
    else $error("final flag set on an empty hold stage");

  a_bits_only_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_v_q && (step_q == ST_BIT) |-> (job_q.op == OP_BODY))
    else $error("bit step on a non-body job");

endmodule

// File: src/graph6_edge_list_decoder.sv
// Graph6 edge list decoder. Bytes of a graph6 string go in through a queue
// style port (push/full) and result words come out through another (empty/pop):
// the vertex count after the header, one word per edge, and a done word with
// the edge count at the end mark, or an error word. The front parser takes one
// byte per cycle while the queue is not full and writes job words into a
// QueueDepth-entry queue; the back walker runs one triangle bit per cycle while
// the result side keeps up, so a body byte occupies it for up to its six bits
// plus, at the end of the string, an end step, and a header job for its head
// step and, at the end of the string, an end step. Result words leave at one
// per cycle while pop is held. An edge word waits in a one-word hold stage
// until the next word or the end of its byte settles its last flag. Depends on
// g6d_pkg.
module graph6_edge_list_decoder #(
  parameter int unsigned QueueDepth = g6d_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  g6d_pkg::in_word_t  in_word_i,
  output logic               empty,
  input  logic               pop,
  output g6d_pkg::out_word_t out_word_o
);
  import g6d_pkg::*;

  logic job_push;
  job_t job_wr;
  logic q_full;
  logic q_empty;
  logic job_take;
  job_t job_rd;

  assign full = q_full;

  // Parse and classify bytes
  g6d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (push),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .job_push_o (job_push),
    .job_o      (job_wr)
  );

  // Buffer jobs between front and back
  g6d_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (job_push),
    .wdata_i (job_wr),
    .full_o  (q_full),
    .rd_i    (job_take),
    .rdata_o (job_rd),
    .empty_o (q_empty)
  );

  // Walk jobs and emit result words
  g6d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_i       (job_rd),
    .job_take_o  (job_take),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_word_o  (out_word_o)
  );

endmodule

// File: sim/testbench.sv
// Self-checking testbench for graph6_edge_list_decoder: drives graph6 strings byte by byte,
// predicts every result word with its own decoder model and checks each popped word.
// Depends on g6d_pkg and the decoder RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import g6d_pkg::*;

  typedef logic [7:0] chars_t[$];

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 60;
  localparam int unsigned SETTLE      = 30;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_word_t  in_word_i;
  logic      empty;
  logic      pop;
  out_word_t out_word_o;

  logic        calm     = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned mismatches   = 0;
  int unsigned bytes_sent   = 0;
  int unsigned quiet_cycles = 0;

  // Decoder state of the prediction side
  ph_e                parse_phase;
  logic [VERT_W-1:0]  vert_count;
  logic [VERT_W-1:0]  hdr_value;
  logic [1:0]         hdr_digits;
  logic [VERT_W-1:0]  walk_col;
  logic [VERT_W-1:0]  walk_row;
  logic [COUNT_W-1:0] edge_tally;

  out_word_t run_words[$];
  out_word_t awaited_words[$];

  graph6_edge_list_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------- prediction

  function automatic void clear_parse();
    parse_phase = PH_START;
    vert_count  = '0;
    hdr_value   = '0;
    hdr_digits  = '0;
    walk_col    = VERT_W'(1);
    walk_row    = '0;
    edge_tally  = '0;
  endfunction

  function automatic void emit(input kind_e kind, input logic [VERT_W-1:0] hi,
                               input logic [VERT_W-1:0] lo, input logic [COUNT_W-1:0] tally,
                               input err_e err);
    out_word_t w;
    w.kind          = kind;
    w.higher_vertex = hi;
    w.lower_vertex  = lo;
    w.tally         = tally;
    w.error_code    = err;
    w.last_of_run   = 1'b0;
    run_words = {run_words, w};
  endfunction

  function automatic void open_body();
    walk_col   = VERT_W'(1);
    walk_row   = '0;
    edge_tally = '0;
    emit(KIND_VCOUNT, '0, '0, COUNT_W'(vert_count), ERR_NONE);
    parse_phase = PH_BODY;
  endfunction

  // Work out the words that one accepted byte causes and queue them
  function automatic void decode_char(input in_word_t w);
    logic [7:0]         b;
    logic [DIGIT_W-1:0] bits;
    int                 k;
    b = w.data_byte;
    run_words = {};
    if (parse_phase == PH_START && b == CHAR_COLON) begin
      parse_phase = PH_COLON;
    end else if (parse_phase == PH_START || parse_phase == PH_COLON) begin
      if (b >= CHAR_BIAS && b < CHAR_LONG) begin
        vert_count = VERT_W'(b - CHAR_BIAS);
        open_body();
      end else if (b == CHAR_LONG) begin
        hdr_value   = '0;
        hdr_digits  = '0;
        parse_phase = PH_DIGITS;
      end else begin
        emit(KIND_ERROR, '0, '0, '0, ERR_HEADER);
        parse_phase = PH_DISCARD;
      end
    end else if (parse_phase == PH_DIGITS) begin
      if (hdr_digits == 2'd0 && b == CHAR_LONG) begin
        emit(KIND_ERROR, '0, '0, '0, ERR_SIZE);
        parse_phase = PH_DISCARD;
      end else begin
        bits       = DIGIT_W'(b - CHAR_BIAS);
        hdr_value  = {hdr_value[VERT_W-DIGIT_W-1:0], bits};
        hdr_digits = hdr_digits + 2'd1;
        if (hdr_digits == 2'd3) begin
          vert_count = hdr_value;
          open_body();
        end
      end
    end else if (parse_phase == PH_BODY) begin
      // Walk the upper triangle column by column, top bit first
      bits = DIGIT_W'(b - CHAR_BIAS);
      for (k = int'(BIT_TOP); k >= 0 && walk_col < vert_count; k--) begin
        if (bits[k]) begin
          emit(KIND_EDGE, VERT_W'(walk_col + 1), VERT_W'(walk_row + 1), '0, ERR_NONE);
          edge_tally = edge_tally + 1'b1;
        end
        walk_row = walk_row + 1'b1;
        if (walk_row >= walk_col) begin
          walk_col = walk_col + 1'b1;
          walk_row = '0;
        end
      end
    end

    if (w.end_of_string) begin
      if (parse_phase == PH_BODY) begin
        if (walk_col < vert_count) emit(KIND_ERROR, '0, '0, '0, ERR_TRUNC);
        else emit(KIND_DONE, '0, '0, edge_tally, ERR_NONE);
      end else if (parse_phase == PH_DIGITS) begin
        emit(KIND_ERROR, '0, '0, '0, ERR_TRUNC);
      end else if (parse_phase == PH_COLON) begin
        emit(KIND_ERROR, '0, '0, '0, ERR_HEADER);
      end
      clear_parse();
    end

    if (run_words.size() != 0) run_words[run_words.size() - 1].last_of_run = 1'b1;
    awaited_words = {awaited_words, run_words};
  endfunction

  // ------------------------------------------------------------------ driving

  // Offer one byte at the falling edge and hold it until the decoder takes it
  task automatic send_byte(input logic [7:0] b, input logic eos);
    in_word_t w;
    w.data_byte     = b;
    w.end_of_string = eos;
    if (!calm && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    push      <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (full);
    decode_char(w);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_string(input chars_t s);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  // Drain result words, with random stalls and an occasional long hold-off
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ----------------------------------------------------------------- checking

  function automatic void check_field(input string name, input logic [COUNT_W-1:0] want,
                                      input logic [COUNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare every popped word with the oldest awaited one
  always @(posedge clk_i) begin : result_check
    out_word_t want;
    if (rst_ni && pop && !empty) begin
      if (awaited_words.size() == 0) begin
        $display("%0t: word with no expectation, expected none got kind %0d tally %0d",
                 $time, out_word_o.kind, out_word_o.tally);
        mismatches++;
      end else begin
        want = awaited_words.pop_front();
        check_field("kind", COUNT_W'(want.kind), COUNT_W'(out_word_o.kind));
        check_field("higher_vertex", COUNT_W'(want.higher_vertex),
                    COUNT_W'(out_word_o.higher_vertex));
        check_field("lower_vertex", COUNT_W'(want.lower_vertex),
                    COUNT_W'(out_word_o.lower_vertex));
        check_field("tally", want.tally, out_word_o.tally);
        check_field("error_code", COUNT_W'(want.error_code),
                    COUNT_W'(out_word_o.error_code));
        check_field("last_of_run", COUNT_W'(want.last_of_run),
                    COUNT_W'(out_word_o.last_of_run));
      end
    end
  end

  // Abort when no word moves on either side for too long
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------- tests

  // One-byte headers: empty graph, single vertex, largest short size cut off
  task automatic test_short_headers();
    send_string({CHAR_BIAS});
    send_string({8'(CHAR_BIAS + 1)});
    send_string({8'(CHAR_LONG - 1)});
  endtask

  // Leading colon, lone colon, colon inside the body, padding after the triangle
  task automatic test_colon_handling();
    send_string({CHAR_COLON, 8'(CHAR_BIAS + 2), 8'(CHAR_BIAS + 32)});
    send_string({CHAR_COLON});
    send_string({8'(CHAR_BIAS + 2), CHAR_COLON, CHAR_LONG});
  endtask

  // Header bytes out of range and the unsupported eight-byte size
  task automatic test_bad_headers();
    send_string({8'd62});
    send_string({8'd255, 8'd0});
    send_string({CHAR_LONG, CHAR_LONG, CHAR_BIAS});
  endtask

  // Four-byte headers: largest size, end inside the digits, digits with high bits set
  task automatic test_long_headers();
    send_string({CHAR_LONG, 8'd62, 8'd62, 8'd62});
    send_string({CHAR_LONG, 8'd0, 8'd255});
    send_string({CHAR_LONG, 8'd191, 8'd127, 8'd65, 8'd0});
  endtask

  // Hold off the result side while a dense graph keeps coming in
  task automatic test_backpressure();
    chars_t s;
    s = {8'(CHAR_BIAS + 9)};
    repeat (6) s = {s, CHAR_LONG};
    hold_req = 1'b1;
    send_string(s);
  endtask

  // Mostly well-formed graphs with random edges; some cut short, padded or noise
  task automatic test_random_graphs(input int unsigned item_goal);
    chars_t      s;
    int unsigned n, nbytes, shape, stop_at;
    stop_at = bytes_sent + item_goal;
    while (bytes_sent < stop_at) begin
      s     = {};
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
        repeat ($urandom_range(1, 4)) s = {s, 8'($urandom)};
      end else begin
        if ($urandom_range(0, 3) == 0) s = {s, CHAR_COLON};
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 9);
        if ($urandom_range(0, 3) != 0) begin
          s = {s, 8'(CHAR_BIAS + n)};
        end else begin
          // Long form: spare high bits of each digit byte must be ignored
          s = {s, CHAR_LONG};
          for (int d = 2; d >= 0; d--) begin
            s = {s, 8'(CHAR_BIAS + ((n >> (DIGIT_W * d)) & 63)
                       + 64 * $urandom_range(0, 3))};
          end
        end
        nbytes = (n * (n - 1) / 2 + DIGIT_W - 1) / DIGIT_W;
        if (shape == 1 && nbytes > 0) nbytes = nbytes - $urandom_range(1, nbytes);
        else if (shape == 2) nbytes = nbytes + $urandom_range(1, 2);
        repeat (nbytes) begin
          s = {s, 8'(CHAR_BIAS + $urandom_range(0, 63) + 64 * $urandom_range(0, 3))};
        end
      end
      send_string(s);
    end
  endtask

  // ------------------------------------------------------------------ sequence

  initial begin
    rst_ni    = 1'b0;
    push      = 1'b0;
    in_word_i = '0;
    clear_parse();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_short_headers();
    test_colon_handling();
    test_bad_headers();
    test_long_headers();
    test_backpressure();
    test_random_graphs(210);
    calm = 1'b1;
    test_random_graphs(30);
    push <= 1'b0;

    // Drain, then give the decoder time to show any stray word
    while (awaited_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/g6d_pkg.sv
src/g6d_fifo.sv
src/g6d_front.sv
src/g6d_back.sv
src/graph6_edge_list_decoder.sv
sim/testbench.sv
